@@ hdl/ukls_pkg.sv @@
// Package for the keyword LED sequencer: payload structs, pattern modes,
// register map, microcode format and program, keyword and pattern tables.
// No dependencies.
package ukls_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       last_result;
    logic [7:0] led_lines;
    logic       busy_res;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ALL   = 2'd1,
    MODE_ALT   = 2'd2,
    MODE_SHIFT = 2'd3
  } mode_e;

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_STEP_TICKS   = 2'd0;
  localparam logic [1:0] REG_REPEAT_COUNT = 2'd1;
  localparam logic [1:0] REG_ALT_MASK     = 2'd2;

  localparam logic [15:0] STEP_TICKS_RST   = 16'd500;
  localparam logic [3:0]  REPEAT_COUNT_RST = 4'd3;
  localparam logic [7:0]  ALT_MASK_RST     = 8'hAA;
  localparam logic [7:0]  LED_OFF          = 8'hFF;
  localparam logic [7:0]  CHAR_NEWLINE     = 8'h0A;

  // Keyword identifiers and text
  localparam logic [1:0] KW_ALL   = 2'd0;
  localparam logic [1:0] KW_ALT   = 2'd1;
  localparam logic [1:0] KW_SHIFT = 2'd2;
  localparam int unsigned KW_NUM  = 3;
  localparam int unsigned KW_ALL_LEN   = 13;
  localparam int unsigned KW_ALT_LEN   = 7;
  localparam int unsigned KW_SHIFT_LEN = 9;
  localparam logic [8*KW_ALL_LEN-1:0]   KW_ALL_TEXT   = {"LED_ALL", "_ONOFF"};
  localparam logic [8*KW_ALT_LEN-1:0]   KW_ALT_TEXT   = "LED_ALT";
  localparam logic [8*KW_SHIFT_LEN-1:0] KW_SHIFT_TEXT = {"LED_", "SHIFT"};

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_STORE,
    OP_START,
    OP_TICK,
    OP_CLEAR,
    OP_EMIT,
    OP_ECHO
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_TICK,
    C_BUSY,
    C_NOT_END,
    C_NO_KW,
    C_OUT_FULL,
    C_MORE
  } cond_e;

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
    logic  done;
  } uword_t;

  localparam upc_t U_FETCH    = 4'd0;
  localparam upc_t U_DISPATCH = 4'd1;
  localparam upc_t U_BYTE     = 4'd2;
  localparam upc_t U_STORE    = 4'd3;
  localparam upc_t U_CHECK    = 4'd4;
  localparam upc_t U_KWCHK    = 4'd5;
  localparam upc_t U_START    = 4'd6;
  localparam upc_t U_CLR      = 4'd7;
  localparam upc_t U_EMIT     = 4'd8;
  localparam upc_t U_TICK     = 4'd9;
  localparam upc_t U_ERD      = 4'd10;
  localparam upc_t U_EOUT     = 4'd11;
  localparam upc_t U_ENEXT    = 4'd12;
  localparam upc_t U_EDONE    = 4'd13;

  // Control store: taken branch goes to target, else next step, or fetch on done
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: U_FETCH, done: 1'b0};
    case (pc)
      U_FETCH:    w = '{op: OP_LATCH, cond: C_NO_IN,    target: U_FETCH, done: 1'b0};
      U_DISPATCH: w = '{op: OP_NOP,   cond: C_TICK,     target: U_TICK,  done: 1'b0};
      U_BYTE:     w = '{op: OP_NOP,   cond: C_BUSY,     target: U_EMIT,  done: 1'b0};
      U_STORE:    w = '{op: OP_STORE, cond: C_NEVER,    target: U_FETCH, done: 1'b0};
      U_CHECK:    w = '{op: OP_NOP,   cond: C_NOT_END,  target: U_EMIT,  done: 1'b0};
      U_KWCHK:    w = '{op: OP_NOP,   cond: C_NO_KW,    target: U_CLR,   done: 1'b0};
      U_START:    w = '{op: OP_START, cond: C_ALWAYS,   target: U_ERD,   done: 1'b0};
      U_CLR:      w = '{op: OP_CLEAR, cond: C_NEVER,    target: U_FETCH, done: 1'b0};
      U_EMIT:     w = '{op: OP_EMIT,  cond: C_OUT_FULL, target: U_EMIT,  done: 1'b1};
      U_TICK:     w = '{op: OP_TICK,  cond: C_ALWAYS,   target: U_EMIT,  done: 1'b0};
      U_ERD:      w = '{op: OP_NOP,   cond: C_NEVER,    target: U_FETCH, done: 1'b0};
      U_EOUT:     w = '{op: OP_ECHO,  cond: C_OUT_FULL, target: U_EOUT,  done: 1'b0};
      U_ENEXT:    w = '{op: OP_NOP,   cond: C_MORE,     target: U_ERD,   done: 1'b0};
      U_EDONE:    w = '{op: OP_CLEAR, cond: C_NEVER,    target: U_FETCH, done: 1'b1};
      default:    w = '{op: OP_NOP,   cond: C_ALWAYS,   target: U_FETCH, done: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(logic [1:0] id);
    logic [3:0] n;
    case (id)
      KW_ALL:   n = 4'(KW_ALL_LEN);
      KW_ALT:   n = 4'(KW_ALT_LEN);
      KW_SHIFT: n = 4'(KW_SHIFT_LEN);
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

  // Character i of a keyword, counted from its first letter; i below its length
  function automatic logic [7:0] kw_char(logic [1:0] id, logic [3:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (id)
      KW_ALL:   ch = KW_ALL_TEXT[8*(KW_ALL_LEN-1-int'(i)) +: 8];
      KW_ALT:   ch = KW_ALT_TEXT[8*(KW_ALT_LEN-1-int'(i)) +: 8];
      KW_SHIFT: ch = KW_SHIFT_TEXT[8*(KW_SHIFT_LEN-1-int'(i)) +: 8];
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Substring match step. All keywords start with "LED_" and 'L' recurs only
  // inside the keyword, so on a mismatch the only prefixes that can survive
  // are "L" and "LE" (the latter when the last matched letter was an 'L').
  function automatic logic [3:0] kw_next(logic [1:0] id, logic [3:0] p, logic [7:0] c);
    logic [3:0] n;
    logic [3:0] len;
    n   = 4'd0;
    len = kw_len(id);
    if (p >= len) begin
      n = len;
    end else if (c == kw_char(id, p)) begin
      n = p + 4'd1;
    end else if (c == "L") begin
      n = 4'd1;
    end else if (c == "E" && p != 4'd0 && kw_char(id, p - 4'd1) == "L") begin
      n = 4'd2;
    end
    return n;
  endfunction

  function automatic logic [3:0] pattern_steps(mode_e mode);
    logic [3:0] n;
    case (mode)
      MODE_ALL:   n = 4'd2;
      MODE_ALT:   n = 4'd2;
      MODE_SHIFT: n = 4'd15;
      default:    n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pattern_led(mode_e mode, logic [3:0] s, logic [7:0] alt);
    logic [7:0] led;
    led = LED_OFF;
    case (mode)
      MODE_ALL: led = (s == 4'd0) ? 8'h00 : LED_OFF;
      MODE_ALT: led = (s == 4'd0) ? alt : ~alt;
      MODE_SHIFT: begin
        if (s < 4'd7) begin
          led = ~(8'h01 << s);
        end else if (s < 4'd15) begin
          led = ~(8'h80 >> (s - 4'd7));
        end
      end
      default: led = LED_OFF;
    endcase
    return led;
  endfunction

endpackage

@@ hdl/uart_keyword_led_sequencer.sv @@
// Keyword LED sequencer top level: microcoded control, line buffer, APB registers.
// Depends on ukls_pkg (types, microcode program, keyword and pattern tables).
// Output: a tick or a byte that ends no matched line gives one transfer; a matched
// line echoes its N bytes (N up to LINE_BYTES), each read from the line buffer,
// sent when the output is free, then checked for more.
// One item at a time: the next item is taken when the program returns to fetch.
// Reset: registers to defaults, line empty, LEDs off; line buffer is not cleared.
module uart_keyword_led_sequencer
  import ukls_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned LW = $clog2(LINE_BYTES + 1);

  logic [15:0] step_ticks_q;
  logic [3:0]  repeat_count_q;
  logic [7:0]  alt_mask_q;

  upc_t        upc_q, upc_d;
  in_item_t    item_q, item_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [3:0]  prog_q [KW_NUM];
  logic [3:0]  prog_d [KW_NUM];
  logic [2:0]  found_q, found_d;
  logic        zero_q, zero_d;
  mode_e       mode_q, mode_d;
  logic [3:0]  rep_q, rep_d;
  logic [3:0]  step_q, step_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  led_q, led_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [7:0]  line_mem [LINE_BYTES];
  logic [7:0]  rd_q;

  uword_t      uw;
  logic        out_free;
  logic        take;

  assign uw       = ucode(upc_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Branch condition and sequencer
  always_comb begin
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !in_valid_i;
      C_TICK:     take = item_q.action;
      C_BUSY:     take = (mode_q != MODE_IDLE);
      C_NOT_END:  take = (item_q.rx_byte != CHAR_NEWLINE) && (len_q < LW'(LINE_BYTES));
      C_NO_KW:    take = (found_q == 3'b000);
      C_OUT_FULL: take = !out_free;
      C_MORE:     take = (idx_q < len_q);
      default:    take = 1'b0;
    endcase
    if (take) begin
      upc_d = uw.target;
    end else if (uw.done) begin
      upc_d = U_FETCH;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  assign in_stall_o = (uw.op != OP_LATCH);

  // Datapath driven by the current control word
  always_comb begin
    logic [15:0] limit;
    logic [16:0] t;
    logic [3:0]  s;
    logic [3:0]  r;
    mode_e       m;
    item_d      = item_q;
    len_d       = len_q;
    idx_d       = idx_q;
    prog_d      = prog_q;
    found_d     = found_q;
    zero_d      = zero_q;
    mode_d      = mode_q;
    rep_d       = rep_q;
    step_d      = step_q;
    tick_d      = tick_q;
    led_d       = led_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    limit       = (step_ticks_q == 16'd0) ? 16'd1 : step_ticks_q;
    t           = {1'b0, tick_q} + 17'd1;
    s           = step_q + 4'd1;
    r           = rep_q + 4'd1;
    m           = found_q[0] ? MODE_ALL : (found_q[1] ? MODE_ALT : MODE_SHIFT);

    case (uw.op)
      OP_LATCH: begin
        if (in_valid_i) begin
          item_d = in_data_i;
        end
      end
      OP_STORE: begin
        len_d = len_q + LW'(1);
        if (item_q.rx_byte == 8'h00) begin
          zero_d = 1'b1;
        end
        // matching halts from the first zero byte to the line end
        if (!zero_q && item_q.rx_byte != 8'h00) begin
          for (int k = 0; k < KW_NUM; k++) begin
            prog_d[k] = kw_next(2'(k), prog_q[k], item_q.rx_byte);
            if (prog_d[k] >= kw_len(2'(k))) begin
              found_d[k] = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        mode_d = MODE_IDLE;
        rep_d  = 4'd0;
        step_d = 4'd0;
        tick_d = 16'd0;
        led_d  = LED_OFF;
        idx_d  = '0;
        if (repeat_count_q != 4'd0) begin
          mode_d = m;
          led_d  = pattern_led(m, 4'd0, alt_mask_q);
        end
      end
      OP_TICK: begin
        if (mode_q != MODE_IDLE) begin
          if (t >= {1'b0, limit}) begin
            tick_d = 16'd0;
            if (s >= pattern_steps(mode_q)) begin
              step_d = 4'd0;
              rep_d  = r;
              if (r >= repeat_count_q) begin
                mode_d = MODE_IDLE;
                rep_d  = 4'd0;
                led_d  = LED_OFF;
              end else begin
                led_d = pattern_led(mode_q, 4'd0, alt_mask_q);
              end
            end else begin
              step_d = s;
              led_d  = pattern_led(mode_q, s, alt_mask_q);
            end
          end else begin
            tick_d = t[15:0];
          end
        end
      end
      OP_CLEAR: begin
        len_d   = '0;
        found_d = 3'b000;
        zero_d  = 1'b0;
        for (int k = 0; k < KW_NUM; k++) begin
          prog_d[k] = 4'd0;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{echo_valid: 1'b0, echo_byte: 8'h00, last_result: 1'b1,
                          led_lines: led_q, busy_res: (mode_q != MODE_IDLE)};
        end
      end
      OP_ECHO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{echo_valid: 1'b1, echo_byte: rd_q,
                          last_result: (idx_q + LW'(1) == len_q),
                          led_lines: led_q, busy_res: (mode_q != MODE_IDLE)};
          idx_d       = idx_q + LW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_FETCH;
      len_q       <= '0;
      idx_q       <= '0;
      found_q     <= 3'b000;
      zero_q      <= 1'b0;
      mode_q      <= MODE_IDLE;
      rep_q       <= 4'd0;
      step_q      <= 4'd0;
      tick_q      <= 16'd0;
      led_q       <= LED_OFF;
      out_valid_q <= 1'b0;
      for (int k = 0; k < KW_NUM; k++) begin
        prog_q[k] <= 4'd0;
      end
    end else begin
      upc_q       <= upc_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      zero_q      <= zero_d;
      mode_q      <= mode_d;
      rep_q       <= rep_d;
      step_q      <= step_d;
      tick_q      <= tick_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
      prog_q      <= prog_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  // Line buffer: write at the fill position, read at the echo position
  always_ff @(posedge clk_i) begin
    if (uw.op == OP_STORE) begin
      line_mem[len_q[AW-1:0]] <= item_q.rx_byte;
    end
    rd_q <= line_mem[idx_q[AW-1:0]];
  end

  // Register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q   <= STEP_TICKS_RST;
      repeat_count_q <= REPEAT_COUNT_RST;
      alt_mask_q     <= ALT_MASK_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[CFG_AW-1:2])
        REG_STEP_TICKS:   step_ticks_q   <= pwdata[15:0];
        REG_REPEAT_COUNT: repeat_count_q <= pwdata[3:0];
        REG_ALT_MASK:     alt_mask_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_STEP_TICKS:   prdata = {16'd0, step_ticks_q};
      REG_REPEAT_COUNT: prdata = {28'd0, repeat_count_q};
      REG_ALT_MASK:     prdata = {24'd0, alt_mask_q};
      default:          prdata = 32'd0;
    endcase
  end

  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/ukls_checker.sv @@
// Port-level checks for the keyword LED sequencer, bound to the top level.
// Depends on ukls_pkg for the payload structs.
module ukls_checker
  import ukls_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a transfer without an echo byte ends its item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.echo_valid |-> out_data_o.last_result)
    else $error("non-echo transfer not marked last");

  a_echo_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.echo_valid |-> out_data_o.echo_byte == 8'h00)
    else $error("echo byte set without echo");

  // idle means all LEDs off
  a_idle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> out_data_o.led_lines == LED_OFF)
    else $error("LEDs lit while idle");

endmodule

bind uart_keyword_led_sequencer ukls_checker u_ukls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ dv/uart_keyword_led_sequencer_test.sv @@
// Self-checking bench for the keyword LED sequencer: line, tick and register traffic
// with a cycle-free scoreboard that predicts echoes, LED lines and the busy flag.
// Depends on ukls_pkg and the uart_keyword_led_sequencer top level.
import ukls_pkg::*;

class sequencer_board #(int unsigned LINE_LEN = 64);
  logic [15:0] step_ticks;
  logic [3:0]  repeat_count;
  logic [7:0]  alt_mask;

  logic [7:0]  line_buf[LINE_LEN];
  int          line_len;
  int          prog[3];
  logic [2:0]  hits;
  bit          zero_seen;
  mode_e       mode;
  logic [3:0]  reps_done;
  logic [3:0]  step_idx;
  logic [15:0] tick_cnt;
  logic [7:0]  leds;

  string       words[3];
  out_item_t   owed[$];
  int          failures;

  function new();
    words[0] = "LED_ALL";
    words[0] = {words[0], "_ONOFF"};
    words[1] = "LED_ALT";
    words[2] = "LED_";
    words[2] = {words[2], "SHIFT"};
    step_ticks = STEP_TICKS_RST;
    repeat_count = REPEAT_COUNT_RST;
    alt_mask = ALT_MASK_RST;
    failures = 0;
    clear_line();
    go_idle();
  endfunction

  function void clear_line();
    line_len = 0;
    prog = '{0, 0, 0};
    hits = '0;
    zero_seen = 1'b0;
  endfunction

  function void go_idle();
    mode = MODE_IDLE;
    reps_done = '0;
    step_idx = '0;
    tick_cnt = '0;
    leds = LED_OFF;
  endfunction

  function bit busy();
    return mode != MODE_IDLE;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_STEP_TICKS:   step_ticks = value[15:0];
      REG_REPEAT_COUNT: repeat_count = value[3:0];
      REG_ALT_MASK:     alt_mask = value[7:0];
      default: ;
    endcase
  endfunction

  // Longest keyword prefix that ends the text seen so far plus c
  function int grow_match(string w, int p, logic [7:0] c);
    bit ok;
    if (p >= w.len()) return w.len();
    for (int k = p + 1; k >= 1; k--) begin
      if (w[k-1] != byte'(c)) continue;
      ok = 1'b1;
      for (int i = 0; i + 1 < k; i++) begin
        if (w[i] != w[p+1-k+i]) ok = 1'b0;
      end
      if (ok) return k;
    end
    return 0;
  endfunction

  function int steps_in(mode_e m);
    case (m)
      MODE_SHIFT:        return 15;
      MODE_ALL, MODE_ALT: return 2;
      default:           return 1;
    endcase
  endfunction

  function logic [7:0] step_leds(mode_e m, int s);
    case (m)
      MODE_ALL:   return (s == 0) ? 8'h00 : LED_OFF;
      MODE_ALT:   return (s == 0) ? alt_mask : ~alt_mask;
      MODE_SHIFT: return (s < 7) ? ~(8'h01 << s) : ~(8'h80 >> (s - 7));
      default:    return LED_OFF;
    endcase
  endfunction

  function void owe(bit ev, logic [7:0] b, bit last);
    out_item_t r;
    r.echo_valid  = ev;
    r.echo_byte   = ev ? b : 8'h00;
    r.last_result = last;
    r.led_lines   = leds;
    r.busy_res    = busy();
    owed.push_back(r);
  endfunction

  // Work out the transfers one accepted input causes
  function void advance(in_item_t it);
    logic [7:0] c;
    int limit;
    int t;
    mode_e m;
    c = it.rx_byte;
    if (it.action) begin
      if (busy()) begin
        limit = (step_ticks == 16'd0) ? 1 : int'(step_ticks);
        t = int'(tick_cnt) + 1;
        if (t >= limit) begin
          tick_cnt = '0;
          step_idx++;
          if (step_idx >= steps_in(mode)) begin
            step_idx = '0;
            reps_done++;
            if (reps_done >= repeat_count) go_idle();
          end
          if (busy()) leds = step_leds(mode, step_idx);
        end else begin
          tick_cnt = t[15:0];
        end
      end
      owe(1'b0, 8'h00, 1'b1);
      return;
    end
    // drop bytes while a pattern runs or the line is full
    if (busy() || line_len >= LINE_LEN) begin
      owe(1'b0, 8'h00, 1'b1);
      return;
    end
    line_buf[line_len] = c;
    line_len++;
    if (c == 8'h00) zero_seen = 1'b1;
    if (!zero_seen) begin
      for (int k = 0; k < 3; k++) begin
        prog[k] = grow_match(words[k], prog[k], c);
        if (prog[k] >= words[k].len()) hits[k] = 1'b1;
      end
    end
    if (c != CHAR_NEWLINE && line_len < LINE_LEN) begin
      owe(1'b0, 8'h00, 1'b1);
      return;
    end
    if (hits == 3'b000) begin
      clear_line();
      owe(1'b0, 8'h00, 1'b1);
      return;
    end
    m = hits[0] ? MODE_ALL : hits[1] ? MODE_ALT : MODE_SHIFT;
    go_idle();
    if (repeat_count != 4'd0) begin
      mode = m;
      leds = step_leds(m, 0);
    end
    for (int i = 0; i < line_len; i++) owe(1'b1, line_buf[i], i + 1 == line_len);
    clear_line();
  endfunction

  function void compare(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      failures++;
    end
  endfunction

  function void check_output(out_item_t got);
    out_item_t want;
    if (owed.size() == 0) begin
      $error("output transfer with nothing predicted: %0h", got);
      failures++;
      return;
    end
    want = owed.pop_front();
    compare("echo_valid", 8'(want.echo_valid), 8'(got.echo_valid));
    compare("echo_byte", want.echo_byte, got.echo_byte);
    compare("last_result", 8'(want.last_result), 8'(got.last_result));
    compare("led_lines", want.led_lines, got.led_lines);
    compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
  endfunction
endclass

module uart_keyword_led_sequencer_test;
  localparam int unsigned LINE_BYTES    = 64;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          DRAIN_CYCLES  = 16;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  sequencer_board #(LINE_BYTES) sb;
  logic [7:0] line_q[$];
  bit calm = 1'b0;
  bit hold;
  int run_left = 0;
  int quiet_cycles = 0;

  uart_keyword_led_sequencer #(.LINE_BYTES(LINE_BYTES)) u_dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CHAR_NEWLINE);
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Receiver side: random runs of stall and flow, no stall while calm
  always @(posedge clk_i) begin
    if (run_left == 0) begin
      hold = !calm && ($urandom_range(0, 2) == 0);
      run_left = hold ? pick_stall() : $urandom_range(1, 8);
      out_stall_i <= hold;
    end else begin
      run_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_output(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Valid stays high between back-to-back items; drop it only for a gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if ($urandom_range(0, 24) == 0) calm = !calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.advance(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item('{action: 1'b0, rx_byte: b});
  endtask

  task automatic send_tick(logic [7:0] b);
    send_item('{action: 1'b1, rx_byte: b});
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic drain_pattern();
    while (sb.busy()) send_tick(rand_byte());
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only once every predicted transfer has come out
  task automatic reconfigure(logic [15:0] ticks, logic [3:0] reps, logic [7:0] mask);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write(REG_STEP_TICKS, 32'(ticks));
    reg_write(REG_REPEAT_COUNT, 32'(reps));
    reg_write(REG_ALT_MASK, 32'(mask));
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) line_q.push_back(noise_byte());
  endfunction

  // Full-length line with no newline, keyword at a random place if with_kw is set
  function automatic void fill_long(bit with_kw);
    string w;
    int pos;
    w = sb.words[$urandom_range(0, 2)];
    pos = $urandom_range(0, LINE_BYTES - w.len());
    add_noise(pos);
    if (with_kw) add_text(w);
    while (line_q.size() < LINE_BYTES) line_q.push_back(noise_byte());
  endfunction

  function automatic void build_line(bit force_long);
    int kind;
    int pos;
    string w;
    line_q.delete();
    kind = force_long ? 100 : $urandom_range(0, 99);
    w = sb.words[$urandom_range(0, 2)];
    if (kind < 50) begin
      add_noise($urandom_range(0, 3));
      // optional partial keyword just before the real one
      case ($urandom_range(0, 4))
        0: add_text("L");
        1: add_text("LE");
        2: add_text("LED_");
        3: add_text("LED_AL");
        default: ;
      endcase
      add_text(w);
      if ($urandom_range(0, 3) == 0) add_text(sb.words[$urandom_range(0, 2)]);
      add_noise($urandom_range(0, 3));
    end else if (kind < 62) begin
      add_text(w);
      pos = $urandom_range(0, w.len() - 1);
      line_q[pos] = ~line_q[pos];
    end else if (kind < 74) begin
      if ($urandom_range(0, 1) == 1) begin
        line_q.push_back(8'h00);
        add_text(w);
      end else begin
        add_text(w);
        line_q.push_back(8'h00);
      end
    end else if (kind < 96) begin
      repeat ($urandom_range(0, 6)) line_q.push_back(rand_byte());
    end else begin
      fill_long(force_long || $urandom_range(0, 1) == 1);
    end
    if (line_q.size() < LINE_BYTES) line_q.push_back(CHAR_NEWLINE);
  endfunction

  task automatic run_random(int count);
    int done_n;
    done_n = 0;
    while (done_n < count) begin
      if (sb.busy()) begin
        if ($urandom_range(0, 99) < 85) begin
          send_tick(rand_byte());
          done_n++;
        end else begin
          send_byte(rand_byte());
        end
      end else if ($urandom_range(0, 99) < 8) begin
        send_tick(rand_byte());
      end else begin
        build_line(1'b0);
        send_line();
        done_n += line_q.size();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: idle tick, zero byte blocking a keyword, then a real match
    send_tick(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("LED_ALT");
    send_byte(CHAR_NEWLINE);
    send_text("LED_ALT");
    send_byte(CHAR_NEWLINE);
    send_byte("A");
    send_tick(8'h00);

    reconfigure(16'd1, 4'd1, 8'h00);
    build_line(1'b1);
    send_line();
    drain_pattern();

    // No repetitions: echo only
    reconfigure(16'hFFFF, 4'd0, 8'hFF);
    run_random(4);

    reconfigure(16'hFFFF, 4'd1, rand_byte());
    run_random(4);

    // Zero step length counts as one tick
    reconfigure(16'd0, 4'd15, rand_byte());
    run_random(8);

    reconfigure(16'd3, 4'd2, rand_byte());
    run_random(6);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/ukls_pkg.sv
hdl/uart_keyword_led_sequencer.sv
hdl/ukls_checker.sv
dv/uart_keyword_led_sequencer_test.sv
